// ----- sv/chc_pkg.sv -----
// ----------------------------------------------------------------------------
// chc_pkg: shared constants and types
// Sizes of the canonical Huffman decoder and the control words between
// the sequencer, the bit buffer and the code tables.
// ----------------------------------------------------------------------------
`default_nettype none

package chc_pkg;

	localparam int MAX_LEVELS  = 16;
	localparam int PREFIX_BITS = 8;
	localparam int ALPHA_SIZE  = 256;
	localparam int LV_W        = $clog2(MAX_LEVELS);
	localparam int LEN_W       = $clog2(MAX_LEVELS + 1);
	localparam int BUF_W       = MAX_LEVELS + 8;
	localparam int CNT_W       = $clog2(BUF_W + 1);
	localparam int ALEN_W      = $clog2(MAX_LEVELS * 255 + 1);

	localparam logic [2:0] STATUS_OK        = 3'd0;
	localparam logic [2:0] STATUS_LEVELS    = 3'd1;
	localparam logic [2:0] STATUS_ALPHA     = 3'd2;
	localparam logic [2:0] STATUS_LEVEL_OVF = 3'd4;
	localparam logic [2:0] STATUS_INDEX     = 3'd5;

	typedef struct packed {
		logic             load;
		logic             drop;
		logic             clear;
		logic [7:0]       data;
		logic [LEN_W-1:0] len;
	} bb_ctrl_t;

	typedef struct packed {
		logic             leaf_we;
		logic             alpha_we;
		logic             build;
		logic             sym_re;
		logic [7:0]       wr_addr;
		logic [7:0]       wr_data;
		logic [LV_W-1:0]  lv_idx;
		logic [LEN_W-1:0] level_count;
		logic [LV_W-1:0]  rd_lv;
		logic [7:0]       sym_addr;
	} tbl_ctrl_t;

endpackage

`default_nettype wire

// ----- sv/chc_bitbuf.sv -----
// ----------------------------------------------------------------------------
// chc_bitbuf: code bit shift register
// Bytes shift in at the bottom; the sequencer reads one bit a cycle
// MSB first and drops a whole code once it matches.
// ----------------------------------------------------------------------------
`default_nettype none

module chc_bitbuf
	import chc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire bb_ctrl_t         ctl,
	input  wire logic [LEN_W-1:0] sel_len,
	output logic                  bit_o,
	output logic [CNT_W-1:0]      avail
);

	logic [BUF_W-1:0] buf_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] pos;

	// shift in a byte, drop a code, or empty the buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q   <= '0;
			buf_q <= '0;
		end else begin
			if (ctl.load)
				buf_q <= {buf_q[BUF_W-9:0], ctl.data};
			if (ctl.clear)
				n_q <= '0;
			else if (ctl.load)
				n_q <= n_q + CNT_W'(8);
			else if (ctl.drop)
				n_q <= n_q - CNT_W'(ctl.len);
		end
	end

	// bit sel_len counted from the oldest valid bit, zero past the end
	assign pos   = n_q - CNT_W'(sel_len);
	assign bit_o = (CNT_W'(sel_len) <= n_q) ? buf_q[pos] : 1'b0;
	assign avail = n_q;

endmodule

`default_nettype wire

// ----- sv/chc_tables.sv -----
// ----------------------------------------------------------------------------
// chc_tables: canonical code tables
// Leaf counts, per-level offsets and code totals, built one level a
// cycle, and the alphabet memory with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module chc_tables
	import chc_pkg::*;
(
	input  wire logic              clk,
	input  wire tbl_ctrl_t         ctl,
	output logic [15:0]            total_rd,
	output logic [15:0]            offset_rd,
	output logic [7:0]             sym_q,
	output logic [ALEN_W-1:0]      alen_next
);

	logic [7:0]        leaves [MAX_LEVELS];
	logic [15:0]       offsets [MAX_LEVELS];
	logic [15:0]       totals [MAX_LEVELS];
	logic [7:0]        alpha_mem [ALPHA_SIZE];
	logic [15:0]       codes_q;
	logic [ALEN_W-1:0] alen_q;
	logic [15:0]       base_codes;
	logic [ALEN_W-1:0] base_alen;
	logic [15:0]       codes2;
	logic [15:0]       codes_n;
	logic [7:0]        leaf;
	logic              in_use;

	// level build step: start from zero at the first level
	always_comb begin
		base_codes = (ctl.lv_idx == '0) ? 16'd0 : codes_q;
		base_alen  = (ctl.lv_idx == '0) ? '0 : alen_q;
		leaf       = leaves[ctl.lv_idx];
		in_use     = LEN_W'(ctl.lv_idx) < ctl.level_count;
		codes2     = {base_codes[14:0], 1'b0};
		codes_n    = codes2 + 16'(leaf);
		alen_next  = in_use ? base_alen + ALEN_W'(leaf) : base_alen;
	end

	always_ff @(posedge clk) begin
		if (ctl.leaf_we)
			leaves[ctl.wr_addr[LV_W-1:0]] <= ctl.wr_data;
		if (ctl.build) begin
			alen_q <= alen_next;
			if (in_use) begin
				codes_q             <= codes_n;
				offsets[ctl.lv_idx] <= 16'(base_alen) - codes2;
				totals[ctl.lv_idx]  <= codes_n;
			end else begin
				codes_q             <= base_codes;
				offsets[ctl.lv_idx] <= 16'd0;
				totals[ctl.lv_idx]  <= 16'd0;
			end
		end
	end

	// alphabet memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (ctl.alpha_we)
			alpha_mem[ctl.wr_addr] <= ctl.wr_data;
		if (ctl.sym_re)
			sym_q <= alpha_mem[ctl.sym_addr];
	end

	assign total_rd  = totals[ctl.rd_lv];
	assign offset_rd = offsets[ctl.rd_lv];

endmodule

`default_nettype wire

// ----- sv/canonical_huffman_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// canonical_huffman_decoder_unit: canonical Huffman decoder
// Parses the header, builds the level tables, then decodes code bits one
// bit per cycle and emits bytes through an output register.
// ----------------------------------------------------------------------------
// Header and alphabet words are taken one per accepted input byte; the table build
// steps through all MAX_LEVELS levels after the last leaf count.
// One result is held back so its last and finished flags are known.
// Reset (arst_n low, asynchronous) returns to header parsing and clears counts.
`default_nettype none

module canonical_huffman_decoder_unit
	import chc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [23:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  in_byte,
	input  wire logic        is_last,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic             last_of_run,
	output logic [2:0]       status,
	output logic             finished
);

	localparam int MAX_RESULTS = 16;
	localparam int K_W         = $clog2(MAX_RESULTS + 1);

	localparam logic [3:0] S_HEADER = 4'd0;
	localparam logic [3:0] S_LEAVES = 4'd1;
	localparam logic [3:0] S_ALPHA  = 4'd2;
	localparam logic [3:0] S_FINLV  = 4'd3;
	localparam logic [3:0] S_WAIT   = 4'd4;
	localparam logic [3:0] S_TOP    = 4'd5;
	localparam logic [3:0] S_BIT    = 4'd6;
	localparam logic [3:0] S_EMIT   = 4'd7;
	localparam logic [3:0] S_ENDP   = 4'd8;
	localparam logic [3:0] S_FLUSH  = 4'd9;
	localparam logic [3:0] S_FINAL  = 4'd10;
	localparam logic [3:0] S_DONE   = 4'd11;
	localparam logic [3:0] S_HALT   = 4'd12;

	logic [3:0]        state_q, nxt_q;
	logic [23:0]       out_len_q;
	logic [LEN_W-1:0]  level_count_q;
	logic              delta_q;
	logic [8:0]        hc_q;
	logic [8:0]        alpha_len_q;
	logic [LV_W-1:0]   lv_q;
	logic [LEN_W-1:0]  len_q;
	logic [15:0]       code_q;
	logic              drain_q;
	logic [K_W-1:0]    k_q;
	logic [7:0]        prev_q;
	logic [23:0]       count_q;
	logic              pend_valid_q;
	logic [7:0]        pend_byte_q;
	logic              fin_q;
	logic [2:0]        fin_status_q;
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              out_last_q;
	logic [2:0]        out_status_q;
	logic              out_fin_q;

	bb_ctrl_t          bb_ctl;
	tbl_ctrl_t         tbl_ctl;
	logic              cur_bit;
	logic [CNT_W-1:0]  avail;
	logic [15:0]       total_rd, offset_rd;
	logic [7:0]        sym_q;
	logic [ALEN_W-1:0] alen_next;

	logic              in_acc, out_free, capped, count_ge, few_bits;
	logic [15:0]       code_new, idx_sum;
	logic              match, beyond, long_code, stop_bit, idx_bad, emit_go;
	logic [7:0]        sym_val;
	logic              push_v, push_last, push_fin;
	logic [7:0]        push_byte;
	logic [2:0]        push_status;

	chc_bitbuf u_bitbuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (bb_ctl),
		.sel_len (len_q),
		.bit_o   (cur_bit),
		.avail   (avail)
	);

	chc_tables u_tables (
		.clk       (clk),
		.ctl       (tbl_ctl),
		.total_rd  (total_rd),
		.offset_rd (offset_rd),
		.sym_q     (sym_q),
		.alen_next (alen_next)
	);

	// handshake and decode conditions
	always_comb begin
		in_acc    = in_valid && !in_stall;
		out_free  = !out_valid_q || !out_stall;
		capped    = k_q >= K_W'(MAX_RESULTS);
		count_ge  = count_q >= out_len_q;
		few_bits  = (avail == '0) || ((avail < CNT_W'(PREFIX_BITS)) && !drain_q);
		code_new  = {code_q[14:0], cur_bit};
		match     = code_new < total_rd;
		beyond    = CNT_W'(len_q) > avail;
		long_code = len_q > LEN_W'(PREFIX_BITS);
		stop_bit  = beyond && (long_code || match);
		idx_sum   = code_new + offset_rd;
		idx_bad   = long_code && (idx_sum[15:8] != 8'd0);
		emit_go   = (state_q == S_EMIT) && (!pend_valid_q || out_free);
		sym_val   = delta_q ? prev_q + sym_q : sym_q;
	end

	// bit buffer and table control words
	always_comb begin
		bb_ctl.load  = (state_q == S_WAIT) && in_acc;
		bb_ctl.data  = in_byte;
		bb_ctl.drop  = emit_go;
		bb_ctl.len   = len_q;
		bb_ctl.clear = ((state_q == S_TOP) && !capped && !count_ge && few_bits && drain_q)
			|| ((state_q == S_BIT) && stop_bit && drain_q);

		tbl_ctl.leaf_we     = (state_q == S_LEAVES) && in_acc;
		tbl_ctl.alpha_we    = (state_q == S_ALPHA) && in_acc;
		tbl_ctl.build       = (state_q == S_FINLV);
		tbl_ctl.sym_re      = (state_q == S_BIT) && !stop_bit && match && !idx_bad;
		tbl_ctl.wr_addr     = hc_q[7:0];
		tbl_ctl.wr_data     = in_byte;
		tbl_ctl.lv_idx      = lv_q;
		tbl_ctl.level_count = level_count_q;
		tbl_ctl.rd_lv       = LV_W'(len_q - LEN_W'(1));
		tbl_ctl.sym_addr    = idx_sum[7:0];
	end

	// select the word pushed into the output register
	always_comb begin
		push_v      = 1'b0;
		push_byte   = pend_byte_q;
		push_last   = 1'b0;
		push_status = STATUS_OK;
		push_fin    = 1'b0;
		case (state_q)
			S_EMIT: begin
				push_v = emit_go && pend_valid_q;
			end
			S_ENDP: begin
				push_v    = out_free;
				push_last = 1'b1;
				push_fin  = fin_q;
			end
			S_FLUSH: begin
				push_v = out_free;
			end
			S_FINAL: begin
				push_v      = out_free;
				push_byte   = 8'd0;
				push_last   = 1'b1;
				push_status = fin_status_q;
				push_fin    = fin_q;
			end
			default: begin
				push_v = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_HEADER;
			nxt_q         <= S_WAIT;
			out_len_q     <= '0;
			level_count_q <= '0;
			delta_q       <= 1'b0;
			hc_q          <= '0;
			alpha_len_q   <= '0;
			lv_q          <= '0;
			len_q         <= '0;
			code_q        <= '0;
			drain_q       <= 1'b0;
			k_q           <= '0;
			prev_q        <= '0;
			count_q       <= '0;
			pend_valid_q  <= 1'b0;
			fin_q         <= 1'b0;
			fin_status_q  <= STATUS_OK;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid)
				out_len_q <= cfg_data;

			// output register
			if (push_v) begin
				out_valid_q  <= 1'b1;
				out_byte_q   <= push_byte;
				out_last_q   <= push_last;
				out_status_q <= push_status;
				out_fin_q    <= push_fin;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (in_acc)
				k_q <= '0;

			case (state_q)
				S_HEADER: begin
					if (in_acc) begin
						delta_q <= in_byte[7];
						if (in_byte[6:0] > 7'(MAX_LEVELS)) begin
							fin_status_q <= STATUS_LEVELS;
							fin_q        <= 1'b0;
							nxt_q        <= S_HALT;
							state_q      <= S_FINAL;
						end else begin
							level_count_q <= in_byte[LEN_W-1:0];
							hc_q          <= '0;
							lv_q          <= '0;
							state_q <= (in_byte[6:0] == 7'd0) ? S_FINLV : S_LEAVES;
						end
					end
				end
				S_LEAVES: begin
					if (in_acc) begin
						hc_q <= hc_q + 9'd1;
						if ((hc_q + 9'd1) >= 9'(level_count_q)) begin
							lv_q    <= '0;
							state_q <= S_FINLV;
						end
					end
				end
				S_FINLV: begin
					if (lv_q == LV_W'(MAX_LEVELS - 1)) begin
						if (alen_next > ALEN_W'(ALPHA_SIZE)) begin
							fin_status_q <= STATUS_ALPHA;
							fin_q        <= 1'b0;
							nxt_q        <= S_HALT;
							state_q      <= S_FINAL;
						end else if (alen_next == '0) begin
							drain_q <= 1'b0;
							state_q <= S_TOP;
						end else begin
							alpha_len_q <= alen_next[8:0];
							hc_q        <= '0;
							state_q     <= S_ALPHA;
						end
					end else begin
						lv_q <= lv_q + LV_W'(1);
					end
				end
				S_ALPHA: begin
					if (in_acc) begin
						hc_q <= hc_q + 9'd1;
						if ((hc_q + 9'd1) >= alpha_len_q) begin
							drain_q <= 1'b0;
							state_q <= S_TOP;
						end
					end
				end
				S_WAIT: begin
					if (in_acc) begin
						drain_q <= is_last;
						state_q <= S_TOP;
					end
				end
				S_TOP: begin
					// check cap, length, then bits on hand
					if (capped) begin
						fin_q   <= 1'b0;
						nxt_q   <= S_WAIT;
						state_q <= pend_valid_q ? S_ENDP : S_WAIT;
					end else if (count_ge) begin
						fin_q        <= 1'b1;
						fin_status_q <= STATUS_OK;
						nxt_q        <= S_DONE;
						state_q      <= pend_valid_q ? S_ENDP : S_FINAL;
					end else if (few_bits) begin
						fin_q   <= 1'b0;
						nxt_q   <= S_WAIT;
						state_q <= pend_valid_q ? S_ENDP : S_WAIT;
					end else begin
						len_q   <= LEN_W'(1);
						code_q  <= '0;
						state_q <= S_BIT;
					end
				end
				S_BIT: begin
					// extend the code by one bit and test it against the level total
					if (stop_bit) begin
						fin_q   <= 1'b0;
						nxt_q   <= S_WAIT;
						state_q <= pend_valid_q ? S_ENDP : S_WAIT;
					end else if (match) begin
						if (idx_bad) begin
							fin_status_q <= STATUS_INDEX;
							fin_q        <= 1'b0;
							nxt_q        <= S_HALT;
							state_q      <= pend_valid_q ? S_FLUSH : S_FINAL;
						end else begin
							state_q <= S_EMIT;
						end
					end else if (len_q == LEN_W'(MAX_LEVELS)) begin
						fin_status_q <= STATUS_LEVEL_OVF;
						fin_q        <= 1'b0;
						nxt_q        <= S_HALT;
						state_q      <= pend_valid_q ? S_FLUSH : S_FINAL;
					end else begin
						len_q  <= len_q + LEN_W'(1);
						code_q <= code_new;
					end
				end
				S_EMIT: begin
					// hold the new byte back until the next decision
					if (emit_go) begin
						pend_valid_q <= 1'b1;
						pend_byte_q  <= sym_val;
						prev_q       <= sym_val;
						count_q      <= count_q + 24'd1;
						k_q          <= k_q + K_W'(1);
						state_q      <= S_TOP;
					end
				end
				S_ENDP: begin
					if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= nxt_q;
					end
				end
				S_FLUSH: begin
					if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= S_FINAL;
					end
				end
				S_FINAL: begin
					if (out_free)
						state_q <= nxt_q;
				end
				S_DONE: begin
					state_q <= S_DONE;
				end
				S_HALT: begin
					state_q <= S_HALT;
				end
				default: begin
					state_q <= S_HEADER;
				end
			endcase
		end
	end

	assign cfg_ready   = 1'b1;
	assign in_stall    = !((state_q == S_HEADER) || (state_q == S_LEAVES)
		|| (state_q == S_ALPHA) || (state_q == S_WAIT)
		|| (state_q == S_DONE) || (state_q == S_HALT));
	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = out_last_q;
	assign status      = out_status_q;
	assign finished    = out_fin_q;

endmodule

`default_nettype wire
